// ----- rtl/ppha_pkg.sv -----
// Shared types and constants of the packed pool handle allocator.
// Request and response payloads, operation and status codes, sizing.
// No dependencies; compile first.
package ppha_pkg;

   localparam int NUM_POOLS      = 4;
   localparam int SLOTS_PER_POOL = 64;

   localparam int POOL_W      = $clog2(NUM_POOLS);
   localparam int SLOT_W      = $clog2(SLOTS_PER_POOL);
   localparam int CNT_W       = $clog2(SLOTS_PER_POOL + 1);
   localparam int ENTRY_COUNT = NUM_POOLS * SLOTS_PER_POOL;
   localparam int ENTRY_W     = POOL_W + SLOT_W;
   localparam int OP_W        = 3;
   localparam int ADDR_W      = 32;
   localparam int SIZE_W      = 16;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;

   typedef logic [OP_W-1:0] op_code_type;

   localparam op_code_type OP_ALLOCATE = 3'd0;
   localparam op_code_type OP_FREE     = 3'd1;
   localparam op_code_type OP_RELEASE  = 3'd2;
   localparam op_code_type OP_GET      = 3'd3;
   localparam op_code_type OP_CLEAR    = 3'd4;

   // register map: bases first, then element sizes
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   localparam csr_idx_type CSR_POOL_BASE_FIRST = 3'd0;
   localparam csr_idx_type CSR_ELEM_SIZE_FIRST = 3'd4;

   typedef enum logic [1:0] {
      STATUS_OK               = 2'd0,
      STATUS_POOL_FULL        = 2'd1,
      STATUS_NOT_LIVE         = 2'd2,
      STATUS_RELEASE_IGNORED  = 2'd3
   } status_type;

   typedef struct packed {
      op_code_type         operation;
      logic [POOL_W-1:0]   pool;
      logic [SLOT_W-1:0]   slot;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [SLOT_W-1:0]   slot_out;
      logic [SLOT_W-1:0]   elem_pos;
      logic [ADDR_W-1:0]   elem_addr;
      logic                copy_needed;
      logic [ADDR_W-1:0]   copy_src_addr;
      logic [ADDR_W-1:0]   copy_dst_addr;
      logic [SLOT_W-1:0]   moved_slot;
      logic [CNT_W-1:0]    live_count;
   } rsp_type;

endpackage

// ----- rtl/ppha_if.sv -----
// Valid/ready channel interfaces of the packed pool handle allocator.
// Depends on ppha_pkg for the request and response payload types.
interface ppha_req_if import ppha_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface ppha_rsp_if import ppha_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/packed_pool_handle_allocator.sv -----
// Packed pool handle allocator: per-pool slot map over a densely packed element array.
// Commands allocate, free, release, get and clear; one response per request.
// Depends on ppha_pkg and the channel interfaces in ppha_if.sv.
//
// One request is in flight at a time. A request is accepted, the two mapping memories
// (slot to element, element to slot) are read on that edge, and on the next edge the
// block writes back and registers the response, which is then offered. The next request
// is taken no earlier than the cycle in which the response leaves, so a new request is
// not taken before the last one is through, and a stalled response holds off the input.
// This is set by the registered read of the mapping memories followed by the write-back.
// Per-slot valid bits, the free maps and live counts live in flip-flops and reset at once,
// so there is no clearing pass after reset.
module packed_pool_handle_allocator import ppha_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   ppha_req_if.sink              req_chan,
   ppha_rsp_if.source            rsp_chan
);

   typedef enum logic {S_IDLE, S_EXEC} state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   rsp_type   rsp_ff;
   rsp_type   rsp_in;
   req_type   cmd_ff;

   logic [ADDR_W-1:0]         base_ff     [NUM_POOLS];
   logic [SIZE_W-1:0]         size_ff     [NUM_POOLS];
   logic [CNT_W-1:0]          count_ff    [NUM_POOLS];
   logic [SLOTS_PER_POOL-1:0] free_map_ff [NUM_POOLS];
   logic [SLOTS_PER_POOL-1:0] valid_ff    [NUM_POOLS];

   logic [SLOT_W-1:0] s2e_mem [ENTRY_COUNT];
   logic [SLOT_W-1:0] e2s_mem [ENTRY_COUNT];
   logic [SLOT_W-1:0] s2e_rdata_ff;
   logic [SLOT_W-1:0] e2s_rdata_ff;

   logic                accept;
   logic [ENTRY_W-1:0]  s2e_raddr;
   logic [ENTRY_W-1:0]  e2s_raddr;
   logic [CNT_W-1:0]    req_last;

   logic                s2e_we;
   logic [ENTRY_W-1:0]  s2e_waddr;
   logic [SLOT_W-1:0]   s2e_wdata;
   logic                e2s_we;
   logic [ENTRY_W-1:0]  e2s_waddr;
   logic [SLOT_W-1:0]   e2s_wdata;

   logic [CNT_W-1:0]          cnt;
   logic [CNT_W-1:0]          cnt_in;
   logic [CNT_W-1:0]          cnt_dec;
   logic [SLOTS_PER_POOL-1:0] free_row;
   logic [SLOTS_PER_POOL-1:0] free_row_in;
   logic [SLOTS_PER_POOL-1:0] valid_row;
   logic [SLOTS_PER_POOL-1:0] valid_row_in;
   logic [SLOT_W-1:0]         found;
   logic                      any_free;
   logic                      slot_live;
   logic [SLOT_W-1:0]         last;
   logic [SLOT_W-1:0]         idx_a;
   logic [ADDR_W-1:0]         addr_a;
   logic [ADDR_W-1:0]         addr_b;

   function automatic logic [ADDR_W-1:0] elem_addr_f(
      input logic [ADDR_W-1:0] base,
      input logic [SIZE_W-1:0] size,
      input logic [SLOT_W-1:0] idx
   );
      logic [SIZE_W+SLOT_W-1:0] prod;
      prod = {{SIZE_W{1'b0}}, idx} * {{SLOT_W{1'b0}}, size};
      return base + ADDR_W'(prod);
   endfunction

   // one request at a time; the write-back edge always precedes the next read
   assign accept         = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_ff;

   assign req_last  = CNT_W'(count_ff[req_chan.data.pool] - 1'b1);
   assign s2e_raddr = {req_chan.data.pool, req_chan.data.slot};
   assign e2s_raddr = {req_chan.data.pool, req_last[SLOT_W-1:0]};

   // lowest free slot of the addressed pool
   always_comb begin
      found = '0;
      for (int i = SLOTS_PER_POOL - 1; i >= 0; i--) begin
         if (free_row[i]) found = SLOT_W'(i);
      end
   end

   assign cnt       = count_ff[cmd_ff.pool];
   assign free_row  = free_map_ff[cmd_ff.pool];
   assign valid_row = valid_ff[cmd_ff.pool];
   assign any_free  = |free_row;
   assign slot_live = valid_row[cmd_ff.slot];
   assign cnt_dec   = CNT_W'(cnt - 1'b1);
   assign last      = cnt_dec[SLOT_W-1:0];
   assign idx_a     = (cmd_ff.operation == OP_ALLOCATE) ? cnt[SLOT_W-1:0] : s2e_rdata_ff;
   assign addr_a    = elem_addr_f(base_ff[cmd_ff.pool], size_ff[cmd_ff.pool], idx_a);
   assign addr_b    = elem_addr_f(base_ff[cmd_ff.pool], size_ff[cmd_ff.pool], last);

   always_comb begin
      rsp_in          = '0;
      rsp_in.status   = STATUS_OK;
      rsp_in.slot_out = cmd_ff.slot;
      cnt_in          = cnt;
      free_row_in     = free_row;
      valid_row_in    = valid_row;
      s2e_we          = 1'b0;
      s2e_waddr       = {cmd_ff.pool, found};
      s2e_wdata       = cnt[SLOT_W-1:0];
      e2s_we          = 1'b0;
      e2s_waddr       = {cmd_ff.pool, cnt[SLOT_W-1:0]};
      e2s_wdata       = found;
      case (cmd_ff.operation)
         OP_ALLOCATE: begin
            if (!any_free || cnt >= CNT_W'(SLOTS_PER_POOL)) begin
               rsp_in.status = STATUS_POOL_FULL;
            end else begin
               free_row_in[found]   = 1'b0;
               valid_row_in[found]  = 1'b1;
               s2e_we               = 1'b1;
               e2s_we               = 1'b1;
               cnt_in               = CNT_W'(cnt + 1'b1);
               rsp_in.slot_out      = found;
               rsp_in.elem_pos      = cnt[SLOT_W-1:0];
               rsp_in.elem_addr     = addr_a;
            end
         end
         OP_FREE: begin
            if (!slot_live || cnt == '0) begin
               rsp_in.status = STATUS_NOT_LIVE;
            end else begin
               rsp_in.elem_pos      = s2e_rdata_ff;
               rsp_in.elem_addr     = addr_a;
               // last element moves into the hole unless the hole is the last one
               if (s2e_rdata_ff != last) begin
                  s2e_we               = 1'b1;
                  s2e_waddr            = {cmd_ff.pool, e2s_rdata_ff};
                  s2e_wdata            = s2e_rdata_ff;
                  e2s_we               = 1'b1;
                  e2s_waddr            = {cmd_ff.pool, s2e_rdata_ff};
                  e2s_wdata            = e2s_rdata_ff;
                  rsp_in.copy_needed   = 1'b1;
                  rsp_in.copy_src_addr = addr_b;
                  rsp_in.copy_dst_addr = addr_a;
                  rsp_in.moved_slot    = e2s_rdata_ff;
               end
               valid_row_in[cmd_ff.slot] = 1'b0;
               cnt_in                    = cnt_dec;
            end
         end
         OP_RELEASE: begin
            if (slot_live) rsp_in.status = STATUS_RELEASE_IGNORED;
            else free_row_in[cmd_ff.slot] = 1'b1;
         end
         OP_GET: begin
            if (!slot_live) begin
               rsp_in.status = STATUS_NOT_LIVE;
            end else begin
               rsp_in.elem_pos      = s2e_rdata_ff;
               rsp_in.elem_addr     = addr_a;
            end
         end
         OP_CLEAR: begin
            cnt_in       = '0;
            free_row_in  = '1;
            valid_row_in = '0;
         end
         default: ;
      endcase
      rsp_in.live_count = cnt_in;
   end

   // sequencer and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_chan.ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  cmd_ff   <= req_chan.data;
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               rsp_ff       <= rsp_in;
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // configuration and per-pool state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < NUM_POOLS; p++) begin
            base_ff[p]     <= '0;
            size_ff[p]     <= SIZE_W'(1);
            count_ff[p]    <= '0;
            free_map_ff[p] <= '1;
            valid_ff[p]    <= '0;
         end
      end else begin
         if (csr_we) begin
            if (csr_index < CSR_ELEM_SIZE_FIRST) begin
               base_ff[csr_index[POOL_W-1:0]] <= csr_wdata[ADDR_W-1:0];
            end else begin
               size_ff[csr_index[POOL_W-1:0]] <= csr_wdata[SIZE_W-1:0];
            end
         end
         if (state_ff == S_EXEC) begin
            count_ff[cmd_ff.pool]    <= cnt_in;
            free_map_ff[cmd_ff.pool] <= free_row_in;
            valid_ff[cmd_ff.pool]    <= valid_row_in;
         end
      end
   end

   // mapping memories, one read and one write port each
   always_ff @(posedge clock) begin
      if (s2e_we && state_ff == S_EXEC) s2e_mem[s2e_waddr] <= s2e_wdata;
      if (accept) s2e_rdata_ff <= s2e_mem[s2e_raddr];
   end

   always_ff @(posedge clock) begin
      if (e2s_we && state_ff == S_EXEC) e2s_mem[e2s_waddr] <= e2s_wdata;
      if (accept) e2s_rdata_ff <= e2s_mem[e2s_raddr];
   end

`ifndef SYNTH
   a_no_accept_during_writeback: assert property (
      @(posedge clock) disable iff (reset)
      state_ff == S_EXEC |-> !req_chan.ready
   ) else $error("request accepted while write-back pending");

   a_rsp_from_exec: assert property (
      @(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_EXEC)
   ) else $error("response raised outside execute cycle");

   a_copy_consistent: assert property (
      @(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.data.copy_needed |->
         rsp_chan.data.status == STATUS_OK &&
         rsp_chan.data.moved_slot != rsp_chan.data.slot_out
   ) else $error("copy reported for a failed free or the freed slot itself");

   a_count_bound: assert property (
      @(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.data.live_count <= CNT_W'(SLOTS_PER_POOL)
   ) else $error("live count beyond pool capacity");

   for (genvar g = 0; g < NUM_POOLS; g++) begin : g_count_chk
      a_count_matches_valid: assert property (
         @(posedge clock) disable iff (reset)
         $countones(valid_ff[g]) == int'(count_ff[g])
      ) else $error("live count disagrees with live slot bits");
   end
`endif

endmodule

// ----- verif/packed_pool_handle_allocator_test.sv -----
// Self-checking bench for packed_pool_handle_allocator: directed table, then biased random.
// Responses are checked against a behavioural slot-map predictor kept in this file.
// Depends on ppha_pkg, the channel interfaces in ppha_if.sv and the allocator RTL.
module packed_pool_handle_allocator_test import ppha_pkg::*; ();

   localparam op_code_type OP_UNUSED_LO  = OP_CLEAR + 3'd1;
   localparam op_code_type OP_UNUSED_MID = OP_CLEAR + 3'd2;
   localparam op_code_type OP_UNUSED_HI  = '1;
   localparam int HOLD_CYCLES = 300;

   typedef struct {
      req_type cmd;
      bit      typed;
      rsp_type rsp;
   } directed_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   csr_idx_type           csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   ppha_req_if req_if ();
   ppha_rsp_if rsp_if ();

   packed_pool_handle_allocator DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state: per-pool slot map over a packed element array
   logic                      slot_live [NUM_POOLS][SLOTS_PER_POOL];
   logic [SLOT_W-1:0]         slot_pos  [NUM_POOLS][SLOTS_PER_POOL];
   logic [SLOT_W-1:0]         pos_slot  [NUM_POOLS][SLOTS_PER_POOL];
   logic [SLOTS_PER_POOL-1:0] free_map  [NUM_POOLS];
   logic [CNT_W-1:0]          live_cnt  [NUM_POOLS];
   logic [ADDR_W-1:0]         base_reg  [NUM_POOLS];
   logic [SIZE_W-1:0]         size_reg  [NUM_POOLS];

   rsp_type          awaited_rsps [$];
   directed_row_type directed_rows [$];

   int fail_count = 0;
   int req_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_asked = 0;
   int hold_granted = 0;
   int hold_left = 0;
   int op_seen [8];
   int status_seen [4];
   int copies_seen = 0;
   int layouts_used = 1;

   function automatic logic [ADDR_W-1:0] element_addr(int p, int idx);
      return base_reg[p] + ADDR_W'(idx) * ADDR_W'(size_reg[p]);
   endfunction

   function automatic void empty_pool(int p);
      live_cnt[p] = '0;
      free_map[p] = '1;
      for (int i = 0; i < SLOTS_PER_POOL; i++) begin
         slot_live[p][i] = 1'b0;
         slot_pos[p][i]  = '0;
      end
   endfunction

   function automatic void reset_pools();
      for (int p = 0; p < NUM_POOLS; p++) begin
         base_reg[p] = '0;
         size_reg[p] = SIZE_W'(1);
         empty_pool(p);
         for (int i = 0; i < SLOTS_PER_POOL; i++) pos_slot[p][i] = '0;
      end
   endfunction

   // Advances the slot map by one request and returns the response it gives.
   function automatic rsp_type apply_pool_command(req_type cmd);
      rsp_type o;
      int      p;
      int      s;
      int      found;
      int      e;
      int      last;
      int      m;
      o          = '0;
      o.status   = STATUS_OK;
      o.slot_out = cmd.slot;
      p          = int'(cmd.pool);
      s          = int'(cmd.slot);
      case (cmd.operation)
         OP_ALLOCATE: begin
            found = -1;
            for (int i = SLOTS_PER_POOL - 1; i >= 0; i--)
               if (free_map[p][i]) found = i;
            if (found < 0 || live_cnt[p] >= SLOTS_PER_POOL) begin
               o.status = STATUS_POOL_FULL;
            end else begin
               e = int'(live_cnt[p]);
               free_map[p][found]  = 1'b0;
               slot_live[p][found] = 1'b1;
               slot_pos[p][found]  = e[SLOT_W-1:0];
               pos_slot[p][e]      = found[SLOT_W-1:0];
               live_cnt[p]         = live_cnt[p] + 1'b1;
               o.slot_out          = found[SLOT_W-1:0];
               o.elem_pos          = e[SLOT_W-1:0];
               o.elem_addr         = element_addr(p, e);
            end
         end
         OP_FREE: begin
            if (!slot_live[p][s] || live_cnt[p] == 0) begin
               o.status = STATUS_NOT_LIVE;
            end else begin
               e    = int'(slot_pos[p][s]);
               last = int'(live_cnt[p]) - 1;
               o.elem_pos  = e[SLOT_W-1:0];
               o.elem_addr = element_addr(p, e);
               if (e != last) begin
                  // last element moves into the hole left by the freed one
                  m = int'(pos_slot[p][last]);
                  slot_pos[p][m]  = e[SLOT_W-1:0];
                  pos_slot[p][e]  = m[SLOT_W-1:0];
                  o.copy_needed   = 1'b1;
                  o.copy_src_addr = element_addr(p, last);
                  o.copy_dst_addr = element_addr(p, e);
                  o.moved_slot    = m[SLOT_W-1:0];
               end
               slot_live[p][s] = 1'b0;
               slot_pos[p][s]  = '0;
               live_cnt[p]     = last[CNT_W-1:0];
            end
         end
         OP_RELEASE: begin
            if (slot_live[p][s]) o.status = STATUS_RELEASE_IGNORED;
            else free_map[p][s] = 1'b1;
         end
         OP_GET: begin
            if (!slot_live[p][s]) begin
               o.status = STATUS_NOT_LIVE;
            end else begin
               e = int'(slot_pos[p][s]);
               o.elem_pos  = e[SLOT_W-1:0];
               o.elem_addr = element_addr(p, e);
            end
         end
         OP_CLEAR: empty_pool(p);
         default: ;
      endcase
      o.live_count = live_cnt[p];
      return o;
   endfunction

   function automatic int pick_live_slot(int p, int fallback);
      int candidates [$];
      for (int i = 0; i < SLOTS_PER_POOL; i++)
         if (slot_live[p][i]) candidates.push_back(i);
      if (candidates.size() == 0) return fallback;
      return candidates[$urandom_range(0, candidates.size() - 1)];
   endfunction

   // dead: freed but not yet released back to the free set
   function automatic int pick_dead_slot(int p, int fallback);
      int candidates [$];
      for (int i = 0; i < SLOTS_PER_POOL; i++)
         if (!slot_live[p][i] && !free_map[p][i]) candidates.push_back(i);
      if (candidates.size() == 0) return fallback;
      return candidates[$urandom_range(0, candidates.size() - 1)];
   endfunction

   function automatic req_type random_request(int alloc_pct, int clear_pct, int pool_sel);
      req_type r;
      int      roll;
      r.pool = (pool_sel < 0) ? POOL_W'($urandom_range(0, NUM_POOLS - 1)) : POOL_W'(pool_sel);
      r.slot = SLOT_W'($urandom);
      roll   = $urandom_range(0, 99);
      if (roll < alloc_pct) begin
         r.operation = OP_ALLOCATE;
      end else if (roll < alloc_pct + clear_pct) begin
         r.operation = OP_CLEAR;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 40) begin
            r.operation = OP_FREE;
            if ($urandom_range(0, 99) < 85) r.slot = SLOT_W'(pick_live_slot(r.pool, r.slot));
         end else if (roll < 62) begin
            r.operation = OP_RELEASE;
            if ($urandom_range(0, 99) < 70) r.slot = SLOT_W'(pick_dead_slot(r.pool, r.slot));
         end else if (roll < 94) begin
            r.operation = OP_GET;
            if ($urandom_range(0, 99) < 80) r.slot = SLOT_W'(pick_live_slot(r.pool, r.slot));
         end else begin
            r.operation = op_code_type'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
         end
      end
      return r;
   endfunction

   function automatic void compare_field(string name, logic [ADDR_W-1:0] want,
                                         logic [ADDR_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endfunction

   function automatic void check_response(rsp_type got);
      rsp_type want;
      if (awaited_rsps.size() == 0) begin
         $error("response with no request outstanding");
         fail_count++;
         return;
      end
      want = awaited_rsps.pop_front();
      compare_field("status", ADDR_W'(want.status), ADDR_W'(got.status));
      compare_field("slot_out", ADDR_W'(want.slot_out), ADDR_W'(got.slot_out));
      compare_field("elem_pos", ADDR_W'(want.elem_pos), ADDR_W'(got.elem_pos));
      compare_field("elem_addr", want.elem_addr, got.elem_addr);
      compare_field("copy_needed", ADDR_W'(want.copy_needed), ADDR_W'(got.copy_needed));
      compare_field("copy_src_addr", want.copy_src_addr, got.copy_src_addr);
      compare_field("copy_dst_addr", want.copy_dst_addr, got.copy_dst_addr);
      compare_field("moved_slot", ADDR_W'(want.moved_slot), ADDR_W'(got.moved_slot));
      compare_field("live_count", ADDR_W'(want.live_count), ADDR_W'(got.live_count));
   endfunction

   // response side: check, then decide ready for the next cycle
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) check_response(rsp_if.data);
         if (hold_asked != hold_granted) begin
            hold_granted = hold_asked;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   task automatic send_request(input req_type cmd, input bit use_typed, input rsp_type typed_rsp);
      rsp_type predicted;
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data  <= cmd;
      do @(posedge clock); while (!req_if.ready);
      predicted = apply_pool_command(cmd);
      if (use_typed) predicted = typed_rsp;
      awaited_rsps.push_back(predicted);
      op_seen[cmd.operation]++;
      status_seen[predicted.status]++;
      if (predicted.copy_needed) copies_seen++;
   endtask

   // leaves valid as it is; the next phase or the drain takes it down
   task automatic run_random(int count, int alloc_pct, int clear_pct, int pool_sel,
                             int idle_pct, int stall_pct);
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (count) send_request(random_request(alloc_pct, clear_pct, pool_sel), 1'b0, '0);
   endtask

   task automatic wait_until_drained();
      req_if.valid <= 1'b0;
      while (awaited_rsps.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input csr_idx_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      if (idx < CSR_ELEM_SIZE_FIRST) base_reg[idx - CSR_POOL_BASE_FIRST] = value;
      else size_reg[idx - CSR_ELEM_SIZE_FIRST] = value[SIZE_W-1:0];
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] b0, b1, b2, b3, s0, s1, s2, s3);
      write_register(CSR_POOL_BASE_FIRST,        b0);
      write_register(CSR_POOL_BASE_FIRST + 3'd1, b1);
      write_register(CSR_POOL_BASE_FIRST + 3'd2, b2);
      write_register(CSR_POOL_BASE_FIRST + 3'd3, b3);
      write_register(CSR_ELEM_SIZE_FIRST,        s0);
      write_register(CSR_ELEM_SIZE_FIRST + 3'd1, s1);
      write_register(CSR_ELEM_SIZE_FIRST + 3'd2, s2);
      write_register(CSR_ELEM_SIZE_FIRST + 3'd3, s3);
      csr_we <= 1'b0;
      layouts_used++;
   endtask

   function automatic void add_row(op_code_type op, int p, int s);
      directed_row_type row;
      row.cmd   = '{operation: op, pool: POOL_W'(p), slot: SLOT_W'(s)};
      row.typed = 1'b0;
      row.rsp   = '0;
      directed_rows.push_back(row);
   endfunction

   // reset layout is base 0, size 1, so the element address equals the index
   function automatic void add_checked(op_code_type op, int p, int s, status_type st,
                                       int slot_out, int idx, int live);
      directed_row_type row;
      row.cmd               = '{operation: op, pool: POOL_W'(p), slot: SLOT_W'(s)};
      row.typed             = 1'b1;
      row.rsp               = '0;
      row.rsp.status        = st;
      row.rsp.slot_out      = SLOT_W'(slot_out);
      row.rsp.elem_pos      = SLOT_W'(idx);
      row.rsp.elem_addr     = ADDR_W'(idx);
      row.rsp.live_count    = CNT_W'(live);
      directed_rows.push_back(row);
   endfunction

   initial begin
      #2000000;
      $display("packed_pool_handle_allocator regression: fail");
      $finish;
   end

   initial begin
      reset        <= 1'b1;
      csr_we       <= 1'b0;
      csr_index    <= '0;
      csr_wdata    <= '0;
      req_if.valid <= 1'b0;
      req_if.data  <= '0;
      for (int i = 0; i < 8; i++) op_seen[i] = 0;
      for (int i = 0; i < 4; i++) status_seen[i] = 0;
      reset_pools();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      add_checked(OP_GET,      0,  0, STATUS_NOT_LIVE,         0, 0, 0);
      add_checked(OP_FREE,     3, 63, STATUS_NOT_LIVE,        63, 0, 0);
      add_checked(OP_RELEASE,  0, 63, STATUS_OK,              63, 0, 0);
      add_checked(OP_ALLOCATE, 0, 63, STATUS_OK,               0, 0, 1);
      add_checked(OP_ALLOCATE, 0,  0, STATUS_OK,               1, 1, 2);
      add_checked(OP_ALLOCATE, 0,  0, STATUS_OK,               2, 2, 3);
      add_checked(OP_RELEASE,  0,  1, STATUS_RELEASE_IGNORED,  1, 0, 3);
      add_checked(OP_GET,      0,  2, STATUS_OK,               2, 2, 3);
      add_row(OP_FREE, 0, 0);             // hole filled from the tail
      add_checked(OP_FREE,     0,  0, STATUS_NOT_LIVE,         0, 0, 2);
      add_row(OP_GET, 0, 2);
      add_row(OP_ALLOCATE, 0, 0);         // dead slot is not handed out again
      add_row(OP_RELEASE, 0, 0);
      add_row(OP_ALLOCATE, 0, 0);
      add_row(OP_FREE, 0, 0);             // last element, no copy
      add_checked(OP_UNUSED_LO,  1, 42, STATUS_OK,            42, 0, 0);
      add_checked(OP_UNUSED_MID, 2, 21, STATUS_OK,            21, 0, 0);
      add_row(OP_UNUSED_HI, 0, 0);
      add_checked(OP_ALLOCATE, 3, 21, STATUS_OK,               0, 0, 1);
      add_checked(OP_GET,      3,  0, STATUS_OK,               0, 0, 1);
      add_checked(OP_FREE,     3,  0, STATUS_OK,               0, 0, 0);
      add_row(OP_RELEASE, 3, 0);
      add_checked(OP_CLEAR,    0, 63, STATUS_OK,              63, 0, 0);
      add_checked(OP_GET,      0,  1, STATUS_NOT_LIVE,         1, 0, 0);
      add_checked(OP_ALLOCATE, 0, 42, STATUS_OK,               0, 0, 1);
      foreach (directed_rows[i])
         send_request(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].rsp);
      wait_until_drained();

      configure(32'h1000_0000, 32'h2000_0000, 32'h0000_4000, 32'hFFFF_F000,
                32'd16, 32'd24, 32'd1, 32'd64);
      run_random(160, 80, 0, 2, 69, 0);   // pool 2 driven to full
      wait_until_drained();
      run_random(200, 40, 2, -1, 0, 69);
      wait_until_drained();

      // extremes: top and bottom bases, size 0 and 0xFFFF with junk above bit 15
      configure(32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'hFFFF_FF00,
                32'h5A5A_FFFF, 32'h0001_0000, 32'd1, 32'hFFFF_8001);
      run_random(200, 55, 1, -1, 18, 18);
      wait_until_drained();

      hold_asked++;
      run_random(80, 50, 1, -1, 0, 0);    // sender keeps offering while responses back up
      wait_until_drained();

      configure($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      run_random(80, 60, 0, 1, 0, 0);
      run_random(80, 30, 2, -1, 69, 69);
      run_random(80, 20, 1, -1, 18, 0);

      req_if.valid <= 1'b0;
      while (awaited_rsps.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("covered %0d requests: alloc %0d, free %0d, release %0d, get %0d,",
               op_seen.sum(), op_seen[OP_ALLOCATE], op_seen[OP_FREE], op_seen[OP_RELEASE],
               op_seen[OP_GET]);
      $display("clear %0d, other %0d; pool full %0d, not live %0d, release ignored %0d,",
               op_seen[OP_CLEAR],
               op_seen[OP_UNUSED_LO] + op_seen[OP_UNUSED_MID] + op_seen[OP_UNUSED_HI],
               status_seen[STATUS_POOL_FULL], status_seen[STATUS_NOT_LIVE],
               status_seen[STATUS_RELEASE_IGNORED]);
      $display("moves %0d, layouts %0d", copies_seen, layouts_used);
      if (fail_count == 0) begin
         $display("packed_pool_handle_allocator regression: pass");
      end else begin
         $display("packed_pool_handle_allocator regression: fail");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/ppha_pkg.sv
rtl/ppha_if.sv
rtl/packed_pool_handle_allocator.sv
verif/packed_pool_handle_allocator_test.sv
